// ----- rtl/core/wlp_pkg.sv -----
// ----------------------------------------------------------------------------
// wlp_pkg
// Shared types and constants of the windowed latency percentile monitor.
// ----------------------------------------------------------------------------
package wlp_pkg;

  // window geometry
  localparam int WINDOW_DEPTH = 1024;
  localparam int SAMPLE_BITS  = 32;
  localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W        = SAMPLE_BITS + ADDR_W;
  localparam int REQ_W        = 32;

  // percentile ranks, slot 0 is p50, slot 1 is p95, slot 2 is p99
  localparam int PCT_NUM = 3;
  localparam int PCT_W   = 7;
  localparam logic [PCT_W-1:0] PCT_DIV = 7'd100;
  localparam logic [PCT_NUM-1:0][PCT_W-1:0] PCT_K = {7'd99, 7'd95, 7'd50};
  localparam int PCT_P50 = 0;
  localparam int PCT_P95 = 1;
  localparam int PCT_P99 = 2;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_GOAL_LIMIT = 1'b0;
  localparam logic [PDATA_W-1:0] GOAL_LIMIT_RESET = 32'd50000;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [PCT_NUM-1:0][ADDR_W-1:0] pct_idx_t;
  typedef logic [PCT_NUM-1:0][SAMPLE_BITS-1:0] pct_val_t;

  // controller states
  typedef enum logic [2:0] {
    C_IDLE,
    C_READ,
    C_START,
    C_SORT,
    C_LOAD
  } ctrl_state_e;

  // sorted-window rebuild states
  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_EV,
    S_TAIL
  } sort_state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic sub_old;
    logic sort_start;
    logic add_new;
    logic load_out;
  } wlp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sort_busy;
    logic out_pending;
  } wlp_status_t;

endpackage

// ----- rtl/core/wlp_ram.sv -----
// ----------------------------------------------------------------------------
// wlp_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module wlp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/core/wlp_sorter.sv -----
// ----------------------------------------------------------------------------
// wlp_sorter
// Sorted copy of one window, rebuilt by a merge pass between two banks.
// ----------------------------------------------------------------------------
module wlp_sorter import wlp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             remove_i,
  input  sample_t          old_i,
  input  sample_t          new_i,
  input  logic [CNT_W-1:0] n_src_i,
  input  pct_idx_t         pct_idx_i,
  output pct_val_t         pct_o,
  output logic             busy_o
);

  sort_state_e state_q, state_d;
  logic             bank_q, bank_d;
  logic [CNT_W-1:0] rd_cnt_q, rd_cnt_d;
  logic [CNT_W-1:0] wr_cnt_q, wr_cnt_d;
  logic             rm_pend_q, rm_pend_d;
  logic             ins_q, ins_d;
  sample_t          old_q, new_q;
  logic [CNT_W-1:0] n_src_q;
  pct_val_t         pct_q;

  logic    emit;
  sample_t emit_data;
  sample_t rdata_a, rdata_b, rdata;

  // bank_q set: source is bank b, destination bank a
  wlp_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_DEPTH)) u_bank_a (
    .clk_i  (clk_i),
    .we_i   (emit && bank_q),
    .waddr_i(wr_cnt_q[ADDR_W-1:0]),
    .wdata_i(emit_data),
    .raddr_i(rd_cnt_q[ADDR_W-1:0]),
    .rdata_o(rdata_a)
  );

  wlp_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_DEPTH)) u_bank_b (
    .clk_i  (clk_i),
    .we_i   (emit && !bank_q),
    .waddr_i(wr_cnt_q[ADDR_W-1:0]),
    .wdata_i(emit_data),
    .raddr_i(rd_cnt_q[ADDR_W-1:0]),
    .rdata_o(rdata_b)
  );

  assign rdata = bank_q ? rdata_b : rdata_a;

  // merge step: drop one copy of the evicted sample, insert the new one
  always_comb begin
    state_d   = state_q;
    bank_d    = bank_q;
    rd_cnt_d  = rd_cnt_q;
    wr_cnt_d  = wr_cnt_q;
    rm_pend_d = rm_pend_q;
    ins_d     = ins_q;
    emit      = 1'b0;
    emit_data = rdata;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          rd_cnt_d  = '0;
          wr_cnt_d  = '0;
          rm_pend_d = remove_i;
          ins_d     = 1'b0;
          state_d   = S_RD;
        end
      end
      S_RD: begin
        if (rd_cnt_q == n_src_q) begin
          state_d = S_TAIL;
        end else begin
          state_d = S_EV;
        end
      end
      S_EV: begin
        if (rm_pend_q && (rdata == old_q)) begin
          rm_pend_d = 1'b0;
          rd_cnt_d  = rd_cnt_q + 1'b1;
          state_d   = S_RD;
        end else if (!ins_q && (new_q < rdata)) begin
          emit      = 1'b1;
          emit_data = new_q;
          ins_d     = 1'b1;
        end else begin
          emit     = 1'b1;
          rd_cnt_d = rd_cnt_q + 1'b1;
          state_d  = S_RD;
        end
      end
      S_TAIL: begin
        if (!ins_q) begin
          emit      = 1'b1;
          emit_data = new_q;
          ins_d     = 1'b1;
        end
        bank_d  = !bank_q;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (emit) begin
      wr_cnt_d = wr_cnt_q + 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      bank_q    <= 1'b0;
      rd_cnt_q  <= '0;
      wr_cnt_q  <= '0;
      rm_pend_q <= 1'b0;
      ins_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      bank_q    <= bank_d;
      rd_cnt_q  <= rd_cnt_d;
      wr_cnt_q  <= wr_cnt_d;
      rm_pend_q <= rm_pend_d;
      ins_q     <= ins_d;
    end
  end

  // operands and captured percentiles
  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == S_IDLE)) begin
      old_q   <= old_i;
      new_q   <= new_i;
      n_src_q <= n_src_i;
    end
    for (int k = 0; k < PCT_NUM; k++) begin
      if (emit && (wr_cnt_q == CNT_W'(pct_idx_i[k]))) begin
        pct_q[k] <= emit_data;
      end
    end
  end

  assign pct_o  = pct_q;
  assign busy_o = (state_q != S_IDLE);

endmodule

// ----- rtl/core/wlp_ctrl.sv -----
// ----------------------------------------------------------------------------
// wlp_ctrl
// Sequencer of one transaction: ring read, sorted rebuild, result load.
// ----------------------------------------------------------------------------
module wlp_ctrl import wlp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  wlp_status_t status_i,
  output wlp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      C_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = C_READ;
        end
      end
      C_READ: begin
        state_d = C_START;
      end
      C_START: begin
        cmd_o.sub_old    = 1'b1;
        cmd_o.sort_start = 1'b1;
        state_d          = C_SORT;
      end
      C_SORT: begin
        if (!status_i.sort_busy) begin
          cmd_o.add_new = 1'b1;
          state_d       = C_LOAD;
        end
      end
      C_LOAD: begin
        if (!status_i.out_pending) begin
          cmd_o.load_out = 1'b1;
          state_d        = C_IDLE;
        end
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/wlp_datapath.sv -----
// ----------------------------------------------------------------------------
// wlp_datapath
// Sample ring, running sums, counters, percentile indexes and result register.
// ----------------------------------------------------------------------------
module wlp_datapath import wlp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  wlp_cmd_t               cmd_i,
  output wlp_status_t            status_o,
  input  logic [31:0]            total_latency_i,
  input  logic [31:0]            processing_latency_i,
  input  logic [PDATA_W-1:0]     goal_limit_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [31:0]            total_p50_o,
  output logic [31:0]            total_p95_o,
  output logic [31:0]            total_p99_o,
  output logic [41:0]            total_sum_o,
  output logic [31:0]            proc_p50_o,
  output logic [31:0]            proc_p95_o,
  output logic [31:0]            proc_p99_o,
  output logic [41:0]            proc_sum_o,
  output logic [10:0]            window_count_o,
  output logic                   goal_met_o,
  output logic [31:0]            request_count_o
);

  logic [CNT_W-1:0]  fill_q;
  logic [ADDR_W-1:0] oldest_q;
  logic [REQ_W-1:0]  req_q;
  logic [SUM_W-1:0]  tsum_q, psum_q;
  sample_t           tv_q, pv_q;
  logic [ADDR_W-1:0] slot_q;
  logic              full_q;
  logic [CNT_W-1:0]  n_src_q;
  pct_idx_t          idx_q;
  logic [PCT_NUM-1:0][PCT_W-1:0] rem_q;
  logic              out_valid_q;

  logic              full_now;
  logic [CNT_W:0]    slot_sum;
  logic [ADDR_W-1:0] slot_now;
  logic [2*SAMPLE_BITS-1:0] ring_rdata;
  sample_t           t_old, p_old;
  pct_val_t          t_pct, p_pct;
  logic              t_busy, p_busy;

  // slot of the incoming sample
  assign full_now = (fill_q == CNT_W'(WINDOW_DEPTH));
  assign slot_sum = {1'b0, fill_q} + (CNT_W + 1)'(oldest_q);
  always_comb begin
    if (full_now) begin
      slot_now = oldest_q;
    end else if (slot_sum >= (CNT_W + 1)'(WINDOW_DEPTH)) begin
      slot_now = ADDR_W'(slot_sum - (CNT_W + 1)'(WINDOW_DEPTH));
    end else begin
      slot_now = ADDR_W'(slot_sum);
    end
  end

  // both rings share one memory, total in the upper half
  wlp_ram #(.WIDTH(2 * SAMPLE_BITS), .DEPTH(WINDOW_DEPTH)) u_ring (
    .clk_i  (clk_i),
    .we_i   (cmd_i.add_new),
    .waddr_i(slot_q),
    .wdata_i({tv_q, pv_q}),
    .raddr_i(slot_q),
    .rdata_o(ring_rdata)
  );

  assign t_old = ring_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign p_old = ring_rdata[SAMPLE_BITS-1:0];

  // sorted windows
  wlp_sorter u_sort_total (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.sort_start),
    .remove_i (full_q),
    .old_i    (t_old),
    .new_i    (tv_q),
    .n_src_i  (n_src_q),
    .pct_idx_i(idx_q),
    .pct_o    (t_pct),
    .busy_o   (t_busy)
  );

  wlp_sorter u_sort_proc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.sort_start),
    .remove_i (full_q),
    .old_i    (p_old),
    .new_i    (pv_q),
    .n_src_i  (n_src_q),
    .pct_idx_i(idx_q),
    .pct_o    (p_pct),
    .busy_o   (p_busy)
  );

  // window state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      oldest_q <= '0;
      req_q    <= '0;
      tsum_q   <= '0;
      psum_q   <= '0;
      idx_q    <= '0;
      rem_q    <= '0;
    end else begin
      if (cmd_i.accept) begin
        req_q <= req_q + 1'b1;
        if (full_now) begin
          if (oldest_q == ADDR_W'(WINDOW_DEPTH - 1)) begin
            oldest_q <= '0;
          end else begin
            oldest_q <= oldest_q + 1'b1;
          end
        end else begin
          fill_q <= fill_q + 1'b1;
          // index k*(n-1)/100 tracked as quotient and remainder
          if (fill_q != '0) begin
            for (int k = 0; k < PCT_NUM; k++) begin
              if (({1'b0, rem_q[k]} + {1'b0, PCT_K[k]}) >= {1'b0, PCT_DIV}) begin
                rem_q[k] <= PCT_W'({1'b0, rem_q[k]} + {1'b0, PCT_K[k]} - {1'b0, PCT_DIV});
                idx_q[k] <= idx_q[k] + 1'b1;
              end else begin
                rem_q[k] <= rem_q[k] + PCT_K[k];
              end
            end
          end
        end
      end
      if (cmd_i.sub_old && full_q) begin
        tsum_q <= tsum_q - SUM_W'(t_old);
        psum_q <= psum_q - SUM_W'(p_old);
      end
      if (cmd_i.add_new) begin
        tsum_q <= tsum_q + SUM_W'(tv_q);
        psum_q <= psum_q + SUM_W'(pv_q);
      end
    end
  end

  // per-transaction operands
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      tv_q    <= total_latency_i;
      pv_q    <= processing_latency_i;
      slot_q  <= slot_now;
      full_q  <= full_now;
      n_src_q <= fill_q;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      total_p50_o     <= t_pct[PCT_P50];
      total_p95_o     <= t_pct[PCT_P95];
      total_p99_o     <= t_pct[PCT_P99];
      total_sum_o     <= tsum_q;
      proc_p50_o      <= p_pct[PCT_P50];
      proc_p95_o      <= p_pct[PCT_P95];
      proc_p99_o      <= p_pct[PCT_P99];
      proc_sum_o      <= psum_q;
      window_count_o  <= fill_q;
      goal_met_o      <= (t_pct[PCT_P99] < goal_limit_i);
      request_count_o <= req_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o.sort_busy   = t_busy || p_busy;
  assign status_o.out_pending = out_valid_q && !out_ready_i;

endmodule

// ----- rtl/core/windowed_latency_percentile.sv -----
// ----------------------------------------------------------------------------
// windowed_latency_percentile
// Sliding-window p50/p95/p99 and sum monitor for total and processing latency.
// ----------------------------------------------------------------------------
// One transaction at a time: an item is held by the merge pass that rebuilds
// each sorted window through one registered RAM read per element already in
// the window (up to 1024 entries once it is full), by a separate write of the
// new sample when it sorts ahead of the last element, and by any wait of the
// previous result on the output.
// The finished result sits in an output register, so the next item is taken
// while it waits. Percentile k is element floor(k*(n-1)/100) of the sorted
// window; goal_met is set when total p99 is strictly below goal_limit_us
// (register 0, reset 50000). No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module windowed_latency_percentile import wlp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // apb-style configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        total_latency_i,
  input  logic [31:0]        processing_latency_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        total_p50_o,
  output logic [31:0]        total_p95_o,
  output logic [31:0]        total_p99_o,
  output logic [41:0]        total_sum_o,
  output logic [31:0]        proc_p50_o,
  output logic [31:0]        proc_p95_o,
  output logic [31:0]        proc_p99_o,
  output logic [41:0]        proc_sum_o,
  output logic [10:0]        window_count_o,
  output logic               goal_met_o,
  output logic [31:0]        request_count_o
);

  logic [PDATA_W-1:0] goal_q;
  logic               reg_sel;
  wlp_cmd_t           cmd;
  wlp_status_t        status;

  // register decode on word index
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_GOAL_LIMIT) && (paddr[1:0] == 2'b00);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_q <= GOAL_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[PADDR_W-1:2] == REG_GOAL_LIMIT)) begin
      goal_q <= pwdata;
    end
  end

  assign prdata = reg_sel ? goal_q : '0;

  wlp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  wlp_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .total_latency_i     (total_latency_i),
    .processing_latency_i(processing_latency_i),
    .goal_limit_i        (goal_q),
    .out_ready_i         (out_ready_i),
    .out_valid_o         (out_valid_o),
    .total_p50_o         (total_p50_o),
    .total_p95_o         (total_p95_o),
    .total_p99_o         (total_p99_o),
    .total_sum_o         (total_sum_o),
    .proc_p50_o          (proc_p50_o),
    .proc_p95_o          (proc_p95_o),
    .proc_p99_o          (proc_p99_o),
    .proc_sum_o          (proc_sum_o),
    .window_count_o      (window_count_o),
    .goal_met_o          (goal_met_o),
    .request_count_o     (request_count_o)
  );

endmodule
